// ===== design/sri_pkg.sv =====
// ----------------------------------------------------------------------------
// sri_pkg
// Shared constants and types for the segment versus rectangle edge test.
// ----------------------------------------------------------------------------
package sri_pkg;

    // Default coordinate width: signed Q11.4.
    localparam int COORD_WIDTH_DEF = 16;

    // One flag for each rectangle edge.
    typedef struct packed {
        logic left;
        logic bottom;
        logic right;
        logic top;
    } t_edges;

endpackage

// ===== design/sri_prod.sv =====
// ----------------------------------------------------------------------------
// sri_prod
// First stage: doubled edge coordinates, segment deltas, the segment-side
// parameter checks and the six products for the edge-side checks.
// ----------------------------------------------------------------------------
module sri_prod #(
    parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH-1:0]         i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0]         i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0]         i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0]         i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0]         i_rect_center_x,
    input  logic signed [COORD_WIDTH-1:0]         i_rect_center_y,
    input  logic        [COORD_WIDTH-2:0]         i_rect_width,
    input  logic        [COORD_WIDTH-2:0]         i_rect_height,
    output logic signed [2*COORD_WIDTH+4:0]       o_prod_at,
    output logic signed [2*COORD_WIDTH+4:0]       o_prod_ab,
    output logic signed [2*COORD_WIDTH+4:0]       o_prod_bl,
    output logic signed [2*COORD_WIDTH+4:0]       o_prod_br,
    output logic signed [2*COORD_WIDTH+1:0]       o_prod_hd,
    output logic signed [2*COORD_WIDTH+1:0]       o_prod_wd,
    output sri_pkg::t_edges                       o_pre_ok
);
    import sri_pkg::*;

    // Delta width and offset width in doubled coordinates.
    localparam int DW = COORD_WIDTH + 2;
    localparam int OW = COORD_WIDTH + 3;
    localparam logic signed [OW-1:0] ZERO = '0;

    logic signed [OW-1:0] sx2, sy2, ex2, ey2, cx2, cy2, w_e, h_e;
    logic signed [OW-1:0] xl, xr, yb, yt;
    logic signed [DW-1:0] dax, day;
    logic signed [OW-1:0] ox_l, ox_r, oy_b, oy_t;
    logic signed [COORD_WIDTH-1:0] w_s, h_s;

    // True when num / den lies in 0..1 inclusive, den taken as nonzero.
    function automatic logic in_unit(input logic signed [OW-1:0] num,
                                     input logic signed [OW-1:0] den);
        if (den[OW-1]) begin
            return (num >= den) && (num <= ZERO);
        end
        return (num >= ZERO) && (num <= den);
    endfunction

    // Double every coordinate so that center +/- half extent is exact.
    assign sx2 = OW'($signed({i_seg_start_x, 1'b0}));
    assign sy2 = OW'($signed({i_seg_start_y, 1'b0}));
    assign ex2 = OW'($signed({i_seg_end_x, 1'b0}));
    assign ey2 = OW'($signed({i_seg_end_y, 1'b0}));
    assign cx2 = OW'($signed({i_rect_center_x, 1'b0}));
    assign cy2 = OW'($signed({i_rect_center_y, 1'b0}));
    assign w_s = $signed({1'b0, i_rect_width});
    assign h_s = $signed({1'b0, i_rect_height});
    assign w_e = OW'(w_s);
    assign h_e = OW'(h_s);

    // Rectangle edges.
    assign xl = cx2 - w_e;
    assign xr = cx2 + w_e;
    assign yb = cy2 - h_e;
    assign yt = cy2 + h_e;

    // Segment direction and offsets of its start from the edge lines.
    assign dax  = DW'(ex2 - sx2);
    assign day  = DW'(ey2 - sy2);
    assign ox_l = sx2 - xl;
    assign ox_r = sx2 - xr;
    assign oy_b = sy2 - yb;
    assign oy_t = sy2 - yt;

    // Segment-side parameter in 0..1, nonzero denominator and side length, per edge.
    assign o_pre_ok.left   = (i_rect_height != '0) && (dax != '0)
                           && in_unit(xl - sx2, OW'(dax));
    assign o_pre_ok.right  = (i_rect_height != '0) && (dax != '0)
                           && in_unit(xr - sx2, OW'(dax));
    assign o_pre_ok.bottom = (i_rect_width != '0) && (day != '0)
                           && in_unit(yb - sy2, OW'(day));
    assign o_pre_ok.top    = (i_rect_width != '0) && (day != '0)
                           && in_unit(yt - sy2, OW'(day));

    // Cross-product terms and signed denominator terms.
    assign o_prod_at = dax * oy_t;
    assign o_prod_ab = dax * oy_b;
    assign o_prod_bl = day * ox_l;
    assign o_prod_br = day * ox_r;
    assign o_prod_hd = h_s * dax;
    assign o_prod_wd = w_s * day;

endmodule

// ===== design/sri_judge.sv =====
// ----------------------------------------------------------------------------
// sri_judge
// Second stage: edge-side parameter checks from the registered products and
// the final hit decision over the left, bottom, right and top sides.
// ----------------------------------------------------------------------------
module sri_judge #(
    parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF
) (
    input  logic signed [2*COORD_WIDTH+4:0]       i_prod_at,
    input  logic signed [2*COORD_WIDTH+4:0]       i_prod_ab,
    input  logic signed [2*COORD_WIDTH+4:0]       i_prod_bl,
    input  logic signed [2*COORD_WIDTH+4:0]       i_prod_br,
    input  logic signed [2*COORD_WIDTH+1:0]       i_prod_hd,
    input  logic signed [2*COORD_WIDTH+1:0]       i_prod_wd,
    input  sri_pkg::t_edges                       i_pre_ok,
    output logic                                  o_hit
);
    import sri_pkg::*;

    localparam int PW = 2 * COORD_WIDTH + 6;
    localparam logic signed [PW-1:0] ZERO = '0;

    logic signed [PW-1:0] c_l, c_b, c_r, c_t;
    logic signed [PW-1:0] den_h, den_w;
    t_edges               edge_ok;

    function automatic logic in_unit(input logic signed [PW-1:0] num,
                                     input logic signed [PW-1:0] den);
        if (den[PW-1]) begin
            return (num >= den) && (num <= ZERO);
        end
        return (num >= ZERO) && (num <= den);
    endfunction

    // Edge-side numerators.
    assign c_l = PW'(i_prod_at) - PW'(i_prod_bl);
    assign c_b = PW'(i_prod_ab) - PW'(i_prod_bl);
    assign c_r = PW'(i_prod_ab) - PW'(i_prod_br);
    assign c_t = PW'(i_prod_at) - PW'(i_prod_br);

    // Denominators: right and top positive forms, left and bottom negated.
    assign den_h = PW'(i_prod_hd) + PW'(i_prod_hd);
    assign den_w = PW'(i_prod_wd) + PW'(i_prod_wd);

    assign edge_ok.left   = i_pre_ok.left   && in_unit(c_l, ZERO - den_h);
    assign edge_ok.bottom = i_pre_ok.bottom && in_unit(c_b, ZERO - den_w);
    assign edge_ok.right  = i_pre_ok.right  && in_unit(c_r, den_h);
    assign edge_ok.top    = i_pre_ok.top    && in_unit(c_t, den_w);

    assign o_hit = |edge_ok;

endmodule

// ===== design/segment_rectangle_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_rectangle_intersect
// Tests a line segment against each side of an axis-aligned rectangle.
// ----------------------------------------------------------------------------
// The block takes one segment and rectangle per cycle while o_stall is low and
// returns one hit bit per beat. The input register loads at the accepting
// edge. The product register, after four multipliers of width (COORD_WIDTH+2)
// by (COORD_WIDTH+3) and two of width COORD_WIDTH by (COORD_WIDTH+2), loads
// next, and the result register, which drives o_valid and o_hit, loads after
// that. The multiplier stage sets the clock period. Every stage
// moves when the one after it is empty or moving, so beats stream at one per
// cycle while the output is taken, and a stalled output holds its result
// while the earlier stages keep filling.
module segment_rectangle_intersect #(
    parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_rect_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_rect_center_y,
    input  logic        [COORD_WIDTH-2:0] i_rect_width,
    input  logic        [COORD_WIDTH-2:0] i_rect_height,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit
);
    import sri_pkg::*;

    localparam int AW = 2 * COORD_WIDTH + 5;
    localparam int HW = 2 * COORD_WIDTH + 2;

    // Input register.
    logic                          r_in_vld;
    logic signed [COORD_WIDTH-1:0] r_sx, r_sy, r_ex, r_ey, r_cx, r_cy;
    logic        [COORD_WIDTH-2:0] r_w, r_h;

    // Product register.
    logic                 r_mid_vld;
    logic signed [AW-1:0] r_at, r_ab, r_bl, r_br;
    logic signed [HW-1:0] r_hd, r_wd;
    t_edges               r_pre_ok;

    // Result register.
    logic r_out_vld;
    logic r_hit;

    logic signed [AW-1:0] n_at, n_ab, n_bl, n_br;
    logic signed [HW-1:0] n_hd, n_wd;
    t_edges               n_pre_ok;
    logic                 n_hit;
    logic                 ld_out, ld_mid, ld_in;

    // Stage advance: a stage loads when it is empty or its contents move on.
    assign ld_out  = !r_out_vld || !i_stall;
    assign ld_mid  = !r_mid_vld || ld_out;
    assign ld_in   = !r_in_vld  || ld_mid;
    assign o_stall = !ld_in;
    assign o_valid = r_out_vld;
    assign o_hit   = r_hit;

    // Capture an input beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (ld_in) begin
            r_in_vld <= i_valid;
        end
        if (ld_in) begin
            r_sx <= i_seg_start_x;
            r_sy <= i_seg_start_y;
            r_ex <= i_seg_end_x;
            r_ey <= i_seg_end_y;
            r_cx <= i_rect_center_x;
            r_cy <= i_rect_center_y;
            r_w  <= i_rect_width;
            r_h  <= i_rect_height;
        end
    end

    sri_prod #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prod (
        .i_seg_start_x   (r_sx),
        .i_seg_start_y   (r_sy),
        .i_seg_end_x     (r_ex),
        .i_seg_end_y     (r_ey),
        .i_rect_center_x (r_cx),
        .i_rect_center_y (r_cy),
        .i_rect_width    (r_w),
        .i_rect_height   (r_h),
        .o_prod_at       (n_at),
        .o_prod_ab       (n_ab),
        .o_prod_bl       (n_bl),
        .o_prod_br       (n_br),
        .o_prod_hd       (n_hd),
        .o_prod_wd       (n_wd),
        .o_pre_ok        (n_pre_ok)
    );

    // Register the products and the segment-side checks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
        end else if (ld_mid) begin
            r_mid_vld <= r_in_vld;
        end
        if (ld_mid) begin
            r_at     <= n_at;
            r_ab     <= n_ab;
            r_bl     <= n_bl;
            r_br     <= n_br;
            r_hd     <= n_hd;
            r_wd     <= n_wd;
            r_pre_ok <= n_pre_ok;
        end
    end

    sri_judge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_judge (
        .i_prod_at (r_at),
        .i_prod_ab (r_ab),
        .i_prod_bl (r_bl),
        .i_prod_br (r_br),
        .i_prod_hd (r_hd),
        .i_prod_wd (r_wd),
        .i_pre_ok  (r_pre_ok),
        .o_hit     (n_hit)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ld_out) begin
            r_out_vld <= r_mid_vld;
        end
        if (ld_out) begin
            r_hit <= n_hit;
        end
    end

    // The input side only stalls when the input register holds a beat.
    a_stall_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld)
        else $error("input stalled with an empty input register");

    // A full pipeline with a stalled output must stall the input.
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_mid_vld && r_out_vld && i_stall) |-> o_stall)
        else $error("input accepted into a full pipeline");

    // An accepted beat occupies the input register next cycle.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_vld)
        else $error("accepted beat lost at the input register");

    // No edge passed the segment-side check, so no hit may be reported.
    a_no_edge_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_vld && ld_out && (r_pre_ok == '0)) |=> !o_hit)
        else $error("hit reported with no candidate edge");

endmodule
